// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the Roman numeral encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/rne_pkg.sv =====
// Types, constants and letter tables of the Roman numeral encoder.
`timescale 1ns / 1ps

package rne_pkg;

    localparam int VALUE_W     = 12;
    localparam int CHAR_W      = 8;
    localparam int CONV_STEPS  = VALUE_W;
    localparam int CNT_W       = $clog2(CONV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(3999);

    localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
    localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
    localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
    localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
    localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

    typedef struct packed {
        logic       err;
        logic [2:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } t_digits;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } t_fr_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_THOU,
        BK_HUND,
        BK_TENS,
        BK_UNIT,
        BK_ERR
    } t_bk_state;

    typedef enum logic [1:0] {
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } t_sym;

    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] len;
        case (d)
            4'd0: len = 3'd0;
            4'd1: len = 3'd1;
            4'd2: len = 3'd2;
            4'd3: len = 3'd3;
            4'd4: len = 3'd2;
            4'd5: len = 3'd1;
            4'd6: len = 3'd2;
            4'd7: len = 3'd3;
            4'd8: len = 3'd4;
            4'd9: len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic t_sym digit_sym(input logic [3:0] d, input logic [1:0] idx);
        t_sym s;
        if (d == 4'd9) begin
            s = (idx == 2'd0) ? SYM_ONE : SYM_TEN;
        end else if (d == 4'd4) begin
            s = (idx == 2'd0) ? SYM_ONE : SYM_FIVE;
        end else if (d >= 4'd5) begin
            s = (idx == 2'd0) ? SYM_FIVE : SYM_ONE;
        end else begin
            s = SYM_ONE;
        end
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] letter(input t_bk_state g, input t_sym s);
        logic [CHAR_W-1:0] ch;
        ch = CH_NONE;
        case (g)
            BK_THOU: ch = CH_M;
            BK_HUND: begin
                case (s)
                    SYM_ONE:  ch = CH_C;
                    SYM_FIVE: ch = CH_D;
                    SYM_TEN:  ch = CH_M;
                    default:  ch = CH_NONE;
                endcase
            end
            BK_TENS: begin
                case (s)
                    SYM_ONE:  ch = CH_X;
                    SYM_FIVE: ch = CH_L;
                    SYM_TEN:  ch = CH_C;
                    default:  ch = CH_NONE;
                endcase
            end
            BK_UNIT: begin
                case (s)
                    SYM_ONE:  ch = CH_I;
                    SYM_FIVE: ch = CH_V;
                    SYM_TEN:  ch = CH_X;
                    default:  ch = CH_NONE;
                endcase
            end
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    // The digit group that follows g and has at least one letter, or idle.
    function automatic t_bk_state next_group(input t_bk_state g, input t_digits dg);
        t_bk_state n;
        n = BK_IDLE;
        case (g)
            BK_THOU: begin
                if (dg.hund != 4'd0) begin
                    n = BK_HUND;
                end else if (dg.tens != 4'd0) begin
                    n = BK_TENS;
                end else if (dg.units != 4'd0) begin
                    n = BK_UNIT;
                end
            end
            BK_HUND: begin
                if (dg.tens != 4'd0) begin
                    n = BK_TENS;
                end else if (dg.units != 4'd0) begin
                    n = BK_UNIT;
                end
            end
            BK_TENS: begin
                if (dg.units != 4'd0) begin
                    n = BK_UNIT;
                end
            end
            default: n = BK_IDLE;
        endcase
        return n;
    endfunction

    function automatic t_bk_state first_group(input t_digits dg);
        t_bk_state n;
        if (dg.err) begin
            n = BK_ERR;
        end else if (dg.thou != 3'd0) begin
            n = BK_THOU;
        end else begin
            n = next_group(BK_THOU, dg);
        end
        return n;
    endfunction

endpackage

// ===== hdl/rne_front.sv =====
// Front end: accepts a value, checks its range and converts it to decimal digits.
`timescale 1ns / 1ps

module rne_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [rne_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_q_push,
    input  logic                         i_q_full,
    output rne_pkg::t_digits             o_q_data
);

    rne_pkg::t_fr_state r_state, n_state;
    logic [rne_pkg::VALUE_W-1:0] r_bin;
    logic [14:0]                 r_bcd;
    logic [rne_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_err;
    logic [14:0]                 w_adj;
    logic                        w_accept;

    function automatic logic [3:0] add3(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? (d + 4'd3) : d;
        return r;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            rne_pkg::FR_IDLE: begin
                if (push) begin
                    n_state = rne_pkg::FR_CONV;
                end
            end
            rne_pkg::FR_CONV: begin
                if (r_cnt == rne_pkg::CNT_W'(rne_pkg::CONV_STEPS - 1)) begin
                    n_state = rne_pkg::FR_PUSH;
                end
            end
            rne_pkg::FR_PUSH: begin
                if (!i_q_full) begin
                    n_state = rne_pkg::FR_IDLE;
                end
            end
            default: n_state = rne_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        full     = (r_state != rne_pkg::FR_IDLE);
        w_accept = push && (r_state == rne_pkg::FR_IDLE);
        o_q_push = (r_state == rne_pkg::FR_PUSH) && !i_q_full;
    end

    assign w_adj = {r_bcd[14:12], add3(r_bcd[11:8]), add3(r_bcd[7:4]), add3(r_bcd[3:0])};

    assign o_q_data = '{err: r_err, thou: r_bcd[14:12], hund: r_bcd[11:8],
                        tens: r_bcd[7:4], units: r_bcd[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rne_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin <= i_value;
            r_bcd <= '0;
            r_cnt <= '0;
            r_err <= (i_value == '0) || (i_value > rne_pkg::VALUE_MAX);
        end else if (r_state == rne_pkg::FR_CONV) begin
            r_bcd <= {w_adj[13:0], r_bin[rne_pkg::VALUE_W-1]};
            r_bin <= {r_bin[rne_pkg::VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

// ===== hdl/rne_queue.sv =====
// Short queue of converted digit sets between the front and back ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rne_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rne_pkg::t_digits i_data,
    output logic             o_full,
    input  logic             i_pop,
    output rne_pkg::t_digits o_data,
    output logic             o_empty
);

    rne_pkg::t_digits r_mem [rne_pkg::QUEUE_DEPTH];
    logic [rne_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [rne_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [rne_pkg::QCNT_W-1:0] r_count;
    logic                       w_wr;
    logic                       w_rd;

    assign o_full  = (r_count == rne_pkg::QCNT_W'(rne_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= rne_pkg::QCNT_W'(rne_pkg::QUEUE_DEPTH))
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_wr && !w_rd, r_count == $past(r_count) + 1'b1)

endmodule

// ===== hdl/rne_back.sv =====
// Back end: spells each digit set as Roman letters or an error item, one character per cycle while pop keeps up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rne_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  rne_pkg::t_digits            i_q_data,
    output logic                        o_q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [rne_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last,
    output logic                        o_error
);

    rne_pkg::t_bk_state r_state, n_state;
    rne_pkg::t_digits   r_dig;
    logic [1:0]                 r_idx;
    logic                       r_out_valid;
    logic [rne_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;
    logic                       r_err;

    logic                       w_can_emit;
    logic                       w_emit;
    logic [3:0]                 w_d;
    logic [2:0]                 w_len;
    rne_pkg::t_sym              w_sym;
    logic                       w_grp_end;
    rne_pkg::t_bk_state         w_after;
    logic                       w_item_end;
    logic [rne_pkg::CHAR_W-1:0] w_char;

    always_comb begin
        w_d = r_dig.units;
        case (r_state)
            rne_pkg::BK_THOU: w_d = {1'b0, r_dig.thou};
            rne_pkg::BK_HUND: w_d = r_dig.hund;
            rne_pkg::BK_TENS: w_d = r_dig.tens;
            rne_pkg::BK_UNIT: w_d = r_dig.units;
            default:          w_d = r_dig.units;
        endcase
    end

    always_comb begin
        w_can_emit = !r_out_valid || pop;
        w_emit     = (r_state != rne_pkg::BK_IDLE) && w_can_emit;
        if (r_state == rne_pkg::BK_THOU) begin
            w_len = r_dig.thou;
            w_sym = rne_pkg::SYM_ONE;
        end else begin
            w_len = rne_pkg::digit_len(w_d);
            w_sym = rne_pkg::digit_sym(w_d, r_idx);
        end
        w_grp_end  = (({1'b0, r_idx} + 3'd1) == w_len) || (r_state == rne_pkg::BK_ERR);
        w_after    = rne_pkg::next_group(r_state, r_dig);
        w_item_end = w_grp_end && (w_after == rne_pkg::BK_IDLE);
        w_char     = (r_state == rne_pkg::BK_ERR) ? rne_pkg::CH_NONE
                                                  : rne_pkg::letter(r_state, w_sym);
        o_q_pop    = !i_q_empty &&
                     ((r_state == rne_pkg::BK_IDLE) || (w_emit && w_item_end));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rne_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = rne_pkg::first_group(i_q_data);
                end
            end
            default: begin
                if (w_emit) begin
                    if (w_item_end) begin
                        n_state = i_q_empty ? rne_pkg::BK_IDLE
                                            : rne_pkg::first_group(i_q_data);
                    end else if (w_grp_end) begin
                        n_state = w_after;
                    end
                end
            end
        endcase
    end

    assign empty       = !r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_error     = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rne_pkg::BK_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop || (w_emit && w_grp_end)) begin
                r_idx <= '0;
            end else if (w_emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_dig <= i_q_data;
        end
        if (w_emit) begin
            r_char <= w_char;
            r_last <= w_item_end;
            r_err  <= (r_state == rne_pkg::BK_ERR);
        end
    end

    `ASSERT_ALWAYS(a_err_is_last, i_clk, i_rst_n, !r_out_valid || !r_err || r_last)
    `ASSERT_ALWAYS(a_letter_present, i_clk, i_rst_n, !r_out_valid || r_err || (r_char != rne_pkg::CH_NONE))
    `ASSERT_ALWAYS(a_idle_index, i_clk, i_rst_n, (r_state != rne_pkg::BK_IDLE) || (r_idx == 2'd0))

endmodule

// ===== hdl/roman_numeral_encoder.sv =====
// An accepted value is converted by the front end, written to the digit queue, popped by the back end and
// spelled from there. The front end converts to decimal digits in 12 steps and takes no new value until it
// has pushed the digit set to the queue. The back end sends one character per cycle while pop keeps up,
// 1 to 15 per value, back to back across values while digit sets are queued.
// Synchronous active-low reset empties the digit queue and the result register.
`timescale 1ns / 1ps

module roman_numeral_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [rne_pkg::VALUE_W-1:0] i_value,
    output logic                        empty,
    input  logic                        pop,
    output logic [rne_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last,
    output logic                        o_error
);

    logic             w_q_push;
    logic             w_q_full;
    logic             w_q_pop;
    logic             w_q_empty;
    rne_pkg::t_digits w_q_in;
    rne_pkg::t_digits w_q_out;

    rne_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_value  (i_value),
        .o_q_push (w_q_push),
        .i_q_full (w_q_full),
        .o_q_data (w_q_in)
    );

    rne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    rne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_out),
        .o_q_pop     (w_q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_character (o_character),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule
